// ===== rtl/sawarq_pkg.sv =====
package sawarq_pkg;

  // packet header layout
  localparam int unsigned HdrWords = 6;
  localparam int unsigned IdxW     = 3;

  // header word positions
  localparam logic [IdxW-1:0] IDX_LEN_LO  = 3'd0;
  localparam logic [IdxW-1:0] IDX_LEN_HI  = 3'd1;
  localparam logic [IdxW-1:0] IDX_PAYLOAD = 3'd2;
  localparam logic [IdxW-1:0] IDX_TYPESEQ = 3'd4;
  localparam logic [IdxW-1:0] IDX_FILE    = 3'd5;
  localparam logic [IdxW-1:0] IDX_DONE    = 3'(HdrWords);

  // link phase codes
  localparam logic [1:0] PH_HANDSHAKE = 2'd0;
  localparam logic [1:0] PH_DATA      = 2'd1;
  localparam logic [1:0] PH_CLOSED    = 2'd2;

  // packet type codes on the wire
  localparam logic [7:0] PKT_SYN     = 8'd1;
  localparam logic [7:0] PKT_SYN_ACK = 8'd2;
  localparam logic [7:0] PKT_ACK     = 8'd4;
  localparam logic [7:0] PKT_FIN_ACK = 8'd8;
  localparam logic [7:0] PKT_NAK     = 8'd32;

  localparam logic [15:0] SUM_GOOD = 16'hffff;
  localparam logic [7:0]  SEQ_INIT = 8'd255;

  // reply queue depth
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    KIND_SYN_ACK = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_FIN_ACK = 2'd2,
    KIND_NAK     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   seq;
    logic [15:0]  sum;
    logic         eor;
    logic         done;
    logic [7:0]   fid;
    logic [31:0]  fbytes;
    logic         closed;
  } reply_t;

  // replies produced by one item, first in r0
  typedef struct packed {
    logic [1:0] cnt;
    reply_t     r0;
    reply_t     r1;
  } push_t;

endpackage

// ===== rtl/sawarq_rx_core.sv =====
module sawarq_rx_core import sawarq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [15:0] word_i,
  input  logic        last_i,
  output push_t       push_o
);

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      acked_q, acked_d;
  logic [15:0]     sum_q, sum_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     tot_q, tot_d;
  logic [15:0]     pay_q, pay_d;
  logic [15:0]     ts_q, ts_d;
  logic [7:0]      file_q, file_d;
  logic [31:0]     rcvd_q, rcvd_d;

  logic [16:0] sum_wide;
  logic [15:0] sum_fold;
  logic [31:0] tot_cap;
  logic [15:0] pay_cap;
  logic [15:0] ts_cap;
  logic [7:0]  file_cap;
  logic        good;
  logic [7:0]  pkt_type, pkt_seq, acked_inc;
  logic [31:0] rcvd_sum;
  logic        file_end;

  // build one reply, header checksum with other fields zero
  function automatic reply_t mk_reply(kind_e k, logic [7:0] seq, logic eor, logic done,
                                      logic [7:0] fid, logic [31:0] fbytes,
                                      logic closed);
    reply_t     r;
    logic [7:0] code;
    case (k)
      KIND_SYN_ACK: code = PKT_SYN_ACK;
      KIND_ACK:     code = PKT_ACK;
      KIND_FIN_ACK: code = PKT_FIN_ACK;
      default:      code = PKT_NAK;
    endcase
    r.kind   = k;
    r.seq    = seq;
    r.sum    = ~{seq, code};
    r.eor    = eor;
    r.done   = done;
    r.fid    = fid;
    r.fbytes = fbytes;
    r.closed = closed;
    return r;
  endfunction

  // end-around-carry sum and header capture including this item
  always_comb begin
    sum_wide = {1'b0, sum_q} + {1'b0, word_i};
    sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};
    tot_cap  = tot_q;
    pay_cap  = pay_q;
    ts_cap   = ts_q;
    file_cap = file_q;
    case (idx_q)
      IDX_LEN_LO:  tot_cap  = {tot_q[31:16], word_i};
      IDX_LEN_HI:  tot_cap  = {word_i, tot_q[15:0]};
      IDX_PAYLOAD: pay_cap  = word_i;
      IDX_TYPESEQ: ts_cap   = word_i;
      IDX_FILE:    file_cap = word_i[7:0];
      default: ;
    endcase
  end

  // receiver rules at packet end
  always_comb begin
    good      = (sum_fold == SUM_GOOD);
    pkt_type  = ts_cap[7:0];
    pkt_seq   = ts_cap[15:8];
    acked_inc = acked_q + 8'd1;
    rcvd_sum  = rcvd_q + {16'd0, pay_cap};
    file_end  = (rcvd_sum == tot_cap);
    phase_d   = phase_q;
    acked_d   = acked_q;
    rcvd_d    = rcvd_q;
    sum_d     = sum_fold;
    idx_d     = (idx_q < IDX_DONE) ? idx_q + 3'd1 : idx_q;
    tot_d     = tot_cap;
    pay_d     = pay_cap;
    ts_d      = ts_cap;
    file_d    = file_cap;
    push_o.cnt = 2'd0;
    push_o.r0  = mk_reply(KIND_NAK, acked_q, 1'b1, 1'b0, 8'd0, 32'd0, 1'b0);
    push_o.r1  = mk_reply(KIND_FIN_ACK, 8'd0, 1'b1, 1'b0, 8'd0, 32'd0, 1'b1);
    if (last_i) begin
      unique case (phase_q)
        PH_HANDSHAKE: begin
          if (good && pkt_type == PKT_SYN) begin
            push_o.cnt = 2'd1;
            push_o.r0  = mk_reply(KIND_SYN_ACK, acked_inc, 1'b1, 1'b0, 8'd0, 32'd0, 1'b0);
            acked_d    = acked_q + 8'd2;
          end
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          if (pkt_type == PKT_FIN_ACK) begin
            if (good) begin
              push_o.cnt = 2'd2;
              push_o.r0  = mk_reply(KIND_ACK, acked_inc, 1'b0, 1'b0, 8'd0, 32'd0, 1'b1);
              acked_d    = acked_q + 8'd2;
            end
            phase_d = PH_CLOSED;
          end else if (good && pkt_seq == acked_inc) begin
            push_o.cnt = 2'd1;
            push_o.r0  = mk_reply(KIND_ACK, pkt_seq, 1'b1, file_end, file_cap, tot_cap,
                                  1'b0);
            acked_d    = pkt_seq;
            rcvd_d     = file_end ? 32'd0 : rcvd_sum;
          end else begin
            push_o.cnt = 2'd1;
          end
        end
        default: ;
      endcase
      // packet captures start over
      sum_d  = 16'd0;
      idx_d  = '0;
      tot_d  = 32'd0;
      pay_d  = 16'd0;
      ts_d   = 16'd0;
      file_d = 8'd0;
    end
    if (!en_i) begin
      push_o.cnt = 2'd0;
    end
  end

  // link and packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HANDSHAKE;
      acked_q <= SEQ_INIT;
      sum_q   <= 16'd0;
      idx_q   <= '0;
      tot_q   <= 32'd0;
      pay_q   <= 16'd0;
      ts_q    <= 16'd0;
      file_q  <= 8'd0;
      rcvd_q  <= 32'd0;
    end else if (en_i) begin
      phase_q <= phase_d;
      acked_q <= acked_d;
      sum_q   <= sum_d;
      idx_q   <= idx_d;
      tot_q   <= tot_d;
      pay_q   <= pay_d;
      ts_q    <= ts_d;
      file_q  <= file_d;
      rcvd_q  <= rcvd_d;
    end
  end

endmodule

// ===== rtl/sawarq_reply_fifo.sv =====
module sawarq_reply_fifo import sawarq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   room_o,
  output logic   valid_o,
  input  logic   ready_i,
  output reply_t data_o
);

  reply_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [QPtrW-1:0] wr_next;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign data_o  = mem_q[rd_q];
  assign wr_next = wr_q + QPtrW'(1);
  assign cnt_d   = cnt_q + QCntW'(push_i.cnt) - QCntW'(pop);

  // reply storage, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.cnt);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/stop_and_wait_arq_receiver_unit.sv =====
// channel   dir  tdata                      tuser        tlast
// s_axis    in   word                       -            last
// m_axis    out  seq,sum,done,id,bytes,cls  reply_kind   end_of_replies
//
// one word per cycle: a word is registered, then folded into the sum and
// header captures once the queue has room; replies of a packet end go to a
// four-entry queue and leave one per cycle, so s_axis stalls only when
// m_axis backs up and the queue holds more than two replies.
// reset brings the link to the handshake phase with no packet in progress.
module stop_and_wait_arq_receiver_unit import sawarq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] word
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] reply_seq, [23:8] reply_sum, [24] file_done, [32:25] file_id,
  // [64:33] file_bytes, [65] link_closed, [71:66] zero
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [1:0] reply_kind
  output logic        m_axis_tlast
);

  logic        in_vld_q;
  logic [15:0] in_word_q;
  logic        in_last_q;
  logic        room;
  logic        advance;
  push_t       push;
  reply_t      head;

  assign advance       = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || advance;

  // input item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  sawarq_rx_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .word_i (in_word_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  sawarq_reply_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  // pack the reply item
  assign m_axis_tdata = {6'd0, head.closed, head.fbytes, head.fid, head.done,
                         head.sum, head.seq};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.eor;

  // replies only come from the final word of a packet
  a_push_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt != 2'd0 |-> advance && in_last_q)
    else $error("reply pushed without packet end");

  // a fin_ack reply always closes the link and ends the replies
  a_finack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_FIN_ACK |-> m_axis_tlast && m_axis_tdata[65])
    else $error("fin_ack reply not final or not closing");

  // a pair of replies is ack then fin_ack, first not marked last
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> push.r0.kind == KIND_ACK && !push.r0.eor
                         && push.r1.kind == KIND_FIN_ACK)
    else $error("bad reply pair");

endmodule

// ===== dv/tb_stop_and_wait_arq_receiver_unit.sv =====
`timescale 1ns / 100ps

import sawarq_pkg::*;

// tracks the receiver link state and the replies it still owes
class link_reply_tracker;
  logic [1:0]  phase      = PH_HANDSHAKE;
  logic [7:0]  last_acked = SEQ_INIT;
  logic [15:0] run_sum    = '0;
  logic [2:0]  word_idx   = '0;
  logic [31:0] hdr_len    = '0;
  logic [15:0] hdr_pay    = '0;
  logic [15:0] hdr_tseq   = '0;
  logic [7:0]  hdr_fid    = '0;
  logic [31:0] bytes_rx   = '0;

  reply_t      replies_due[$];

  int unsigned n_words     = 0;
  int unsigned n_packets   = 0;
  int unsigned n_replies   = 0;
  int unsigned n_files     = 0;
  int unsigned n_ignored   = 0;
  int unsigned errors      = 0;
  int unsigned kind_seen[4];

  // reply header checksum covers type code and sequence, other fields zero
  function reply_t make_reply(kind_e k, logic [7:0] seq, logic eor, logic done,
                              logic [7:0] fid, logic [31:0] fbytes, logic closed);
    reply_t     r;
    logic [7:0] code;
    case (k)
      KIND_SYN_ACK: code = PKT_SYN_ACK;
      KIND_ACK:     code = PKT_ACK;
      KIND_FIN_ACK: code = PKT_FIN_ACK;
      default:      code = PKT_NAK;
    endcase
    r.kind   = k;
    r.seq    = seq;
    r.sum    = ~{seq, code};
    r.eor    = eor;
    r.done   = done;
    r.fid    = fid;
    r.fbytes = fbytes;
    r.closed = closed;
    return r;
  endfunction

  // fold one accepted item into the packet and apply the link rules at its end
  function void absorb_word(logic [15:0] w, logic l);
    logic [16:0] wide;
    logic [15:0] s;
    logic        good;
    logic        done;
    logic [7:0]  ptype;
    logic [7:0]  pseq;
    wide = {1'b0, run_sum} + {1'b0, w};
    s = wide[15:0] + {15'd0, wide[16]};
    n_words++;
    case (word_idx)
      IDX_LEN_LO:  hdr_len[15:0]  = w;
      IDX_LEN_HI:  hdr_len[31:16] = w;
      IDX_PAYLOAD: hdr_pay        = w;
      IDX_TYPESEQ: hdr_tseq       = w;
      IDX_FILE:    hdr_fid        = w[7:0];
      default: ;
    endcase
    if (word_idx < IDX_DONE) word_idx++;
    run_sum = s;
    if (!l) return;

    n_packets++;
    good  = (s == SUM_GOOD);
    ptype = hdr_tseq[7:0];
    pseq  = hdr_tseq[15:8];
    case (phase)
      PH_HANDSHAKE: begin
        if (good && ptype == PKT_SYN) begin
          replies_due.push_back(make_reply(KIND_SYN_ACK, last_acked + 8'd1,
                                           1'b1, 1'b0, '0, '0, 1'b0));
          last_acked = last_acked + 8'd2;
        end
        phase = PH_DATA;
      end
      PH_DATA: begin
        if (ptype == PKT_FIN_ACK) begin
          // close: ack then fin_ack when intact, silence otherwise
          if (good) begin
            replies_due.push_back(make_reply(KIND_ACK, last_acked + 8'd1,
                                             1'b0, 1'b0, '0, '0, 1'b1));
            last_acked = last_acked + 8'd2;
            replies_due.push_back(make_reply(KIND_FIN_ACK, 8'd0,
                                             1'b1, 1'b0, '0, '0, 1'b1));
          end
          phase = PH_CLOSED;
        end else if (good && pseq == last_acked + 8'd1) begin
          last_acked = pseq;
          bytes_rx = bytes_rx + {16'd0, hdr_pay};
          done = (bytes_rx == hdr_len);
          replies_due.push_back(make_reply(KIND_ACK, last_acked, 1'b1, done,
                                           hdr_fid, hdr_len, 1'b0));
          if (done) begin
            bytes_rx = '0;
            n_files++;
          end
        end else begin
          replies_due.push_back(make_reply(KIND_NAK, last_acked, 1'b1, 1'b0,
                                           '0, '0, 1'b0));
        end
      end
      default: n_ignored++;
    endcase
    run_sum  = '0;
    word_idx = '0;
    hdr_len  = '0;
    hdr_pay  = '0;
    hdr_tseq = '0;
    hdr_fid  = '0;
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // compare one accepted reply against the oldest one owed
  function void match_reply(logic [1:0] kind, logic [71:0] data, logic eor);
    reply_t want;
    if (replies_due.size() == 0) begin
      $display("%0t ns: unexpected reply, expected none actual kind %0d data %h",
               $time, kind, data);
      errors++;
      return;
    end
    want = replies_due.pop_front();
    n_replies++;
    kind_seen[kind]++;
    check_field("reply_kind", 32'(want.kind), 32'(kind));
    check_field("reply_seq", 32'(want.seq), 32'(data[7:0]));
    check_field("reply_sum", 32'(want.sum), 32'(data[23:8]));
    check_field("end_of_replies", 32'(want.eor), 32'(eor));
    check_field("file_done", 32'(want.done), 32'(data[24]));
    check_field("file_id", 32'(want.fid), 32'(data[32:25]));
    check_field("file_bytes", want.fbytes, data[64:33]);
    check_field("link_closed", 32'(want.closed), 32'(data[65]));
    check_field("pad bits", 32'd0, 32'(data[71:66]));
  endfunction
endclass

module tb_stop_and_wait_arq_receiver_unit;

  localparam int unsigned GapMax      = 10;
  localparam int unsigned HoldAfter   = 30;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned WordTarget  = 550;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 16;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  link_reply_tracker tracker = new;
  logic [15:0]       pkt_words[$];
  logic              send_burst  = 1'b0;
  logic              take_burst  = 1'b0;
  int unsigned       idle_cycles = 0;

  stop_and_wait_arq_receiver_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t ns: no item moved for %0d cycles", $time, IdleLimit);
      $display("FAIL stop_and_wait_arq_receiver_unit");
      $finish;
    end
  end

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[15:0] + {15'd0, wide[16]};
  endfunction

  // header plus trailing words, checksum field set so the packet folds to all ones
  task automatic build_packet(input logic [7:0] ptype, input logic [7:0] pseq,
                              input logic [15:0] pay_len, input logic [31:0] total,
                              input logic [7:0] fid, input int unsigned n_extra);
    logic [15:0] fold;
    logic [7:0]  spare;
    spare = 8'($urandom);
    pkt_words.delete();
    pkt_words.push_back(total[15:0]);
    pkt_words.push_back(total[31:16]);
    pkt_words.push_back(pay_len);
    pkt_words.push_back(16'h0000);
    pkt_words.push_back({pseq, ptype});
    pkt_words.push_back({spare, fid});
    repeat (n_extra) pkt_words.push_back(16'($urandom));
    fold = '0;
    foreach (pkt_words[i]) fold = ones_add(fold, pkt_words[i]);
    pkt_words[3] = ~fold;
  endtask

  // data packet: mostly in order and intact, some out of order or corrupted
  task automatic next_data_packet();
    logic [7:0]  ptype;
    logic [7:0]  pseq;
    logic [15:0] pay_len;
    logic [31:0] total;
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0: ptype = PKT_SYN;
      1: ptype = PKT_SYN_ACK;
      2: ptype = PKT_ACK;
      3: ptype = PKT_NAK;
      default: begin
        ptype = 8'($urandom);
        if (ptype == PKT_FIN_ACK) ptype = PKT_ACK;
      end
    endcase
    pseq = tracker.last_acked + 8'd1;
    if (pick >= 85) pseq = pseq + 8'($urandom_range(1, 255));
    case ($urandom_range(0, 9))
      0: pay_len = 16'h0000;
      1: pay_len = 16'hffff;
      default: pay_len = 16'($urandom_range(1, 1500));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: total = tracker.bytes_rx + {16'd0, pay_len};
      4: total = 32'hffff_ffff;
      5: total = 32'h0;
      default: total = $urandom;
    endcase
    build_packet(ptype, pseq, pay_len, total, 8'($urandom), $urandom_range(0, 3));
    // flip bits anywhere but the type word
    if (pick >= 75 && pick < 85) begin
      idx = $urandom_range(0, pkt_words.size() - 1);
      if (idx == 4) idx = 3;
      pkt_words[idx] = pkt_words[idx] ^ 16'($urandom_range(1, 16'hfffe));
    end
  endtask

  // random words of random length, never a close request
  task automatic next_noise_packet();
    int unsigned len;
    len = $urandom_range(1, 9);
    pkt_words.delete();
    repeat (len) pkt_words.push_back(16'($urandom));
    if (len >= 5 && pkt_words[4][7:0] == PKT_FIN_ACK) pkt_words[4][7:0] = PKT_NAK;
  endtask

  // offer the packet one item at a time with random gaps
  task automatic send_packet();
    int unsigned gap;
    send_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < pkt_words.size(); i++) begin
      gap = send_burst ? 0 : $urandom_range(0, GapMax);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pkt_words[i];
      s_axis_tlast  <= (i == pkt_words.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      tracker.absorb_word(pkt_words[i], i == pkt_words.size() - 1);
    end
  endtask

  // reply side: random stalls, bursts, and one long hold-off
  initial begin : reply_sink
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 8 == 0) take_burst = ($urandom_range(0, 2) == 0);
      gap = take_burst ? 0 : $urandom_range(0, GapMax);
      if (taken == HoldAfter) gap = HoldCycles;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      tracker.match_reply(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      taken++;
    end
  end

  // packet stimulus
  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // handshake with all-ones length, payload and file fields
    build_packet(PKT_SYN, 8'h00, 16'hffff, 32'hffff_ffff, 8'hff, 0);
    send_packet();
    // one-word packet, missing header reads as zero
    pkt_words.delete();
    pkt_words.push_back(16'h0000);
    send_packet();
    // empty file completes at once
    build_packet(PKT_ACK, tracker.last_acked + 8'd1, 16'h0000, 32'h0, 8'h00, 0);
    send_packet();
    // repeat of the sequence just acked
    build_packet(PKT_ACK, tracker.last_acked, 16'd10, 32'd100, 8'h5a, 0);
    send_packet();

    while (tracker.n_words < WordTarget) begin
      if ($urandom_range(0, 9) == 0) next_noise_packet();
      else next_data_packet();
      send_packet();
    end

    // close the link, then traffic the closed link drops
    build_packet(PKT_FIN_ACK, 8'($urandom), 16'h0000, 32'h0, 8'h00, 0);
    send_packet();
    repeat (2) begin
      build_packet(PKT_ACK, tracker.last_acked + 8'd1, 16'd1, 32'd1, 8'h01, 1);
      send_packet();
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run: %0d items in %0d packets, %0d replies checked, %0d files done",
             tracker.n_words, tracker.n_packets, tracker.n_replies, tracker.n_files);
    $display("run: syn_ack %0d, ack %0d, fin_ack %0d, nak %0d, %0d dropped after close",
             tracker.kind_seen[KIND_SYN_ACK], tracker.kind_seen[KIND_ACK],
             tracker.kind_seen[KIND_FIN_ACK], tracker.kind_seen[KIND_NAK],
             tracker.n_ignored);
    if (tracker.errors == 0) begin
      $display("PASS stop_and_wait_arq_receiver_unit");
    end else begin
      $display("FAIL stop_and_wait_arq_receiver_unit");
    end
    $finish;
  end

endmodule

// ===== stop_and_wait_arq_receiver_unit.f =====
rtl/sawarq_pkg.sv
rtl/sawarq_rx_core.sv
rtl/sawarq_reply_fifo.sv
rtl/stop_and_wait_arq_receiver_unit.sv
dv/tb_stop_and_wait_arq_receiver_unit.sv
